// ===== rtl/fmcg_pkg.sv =====
// ----------------------------------------------------------------------------
// fmcg_pkg
// Types, constants and helper functions shared by the mask coefficient blocks
// ----------------------------------------------------------------------------
package fmcg_pkg;

  localparam int MAX_DIM = 64;

  localparam int KW   = 2;   // kind register
  localparam int DW   = 7;   // height / width registers
  localparam int IW   = 6;   // row / column index
  localparam int CW   = 25;  // coefficient
  localparam int AW   = 4;   // apb address
  localparam int HWW  = 13;  // height * width
  localparam int NUMW = 40;  // exponent numerator, q32
  localparam int DENW = 12;  // exponent denominator, integer
  localparam int D2W  = 13;  // squared distance
  localparam int NW   = 51;  // dividend d2*num + den/2
  localparam int XW   = 37;  // exponent argument, q32 (larger values give zero)
  localparam int NBW  = 6;   // integer multiple of ln2
  localparam int FW   = 32;  // fraction left after removing n*ln2
  localparam int EW   = 33;  // series sum, q32
  localparam int PW   = HWW + EW;
  localparam int TERMS = 20;
  localparam int NSTEP = TERMS - 2;  // series steps after the first term
  localparam int QK   = 35;  // reciprocal scale for the divide by a term index
  localparam int MW   = 35;

  localparam logic [31:0]   LN2       = 32'hB17217F8;
  localparam logic [32:0]   LN3       = 33'h1193EA7AB;
  localparam logic [CW-1:0] ONE_Q12   = CW'(4096);
  localparam logic [CW-1:0] COEF_MAX  = {CW{1'b1}};
  localparam logic [NBW-1:0] N_ZERO   = NBW'(40);
  localparam logic [6:0]    SHIFT_BASE = 7'd20;

  localparam logic [KW-1:0] KIND_RST   = 2'd0;
  localparam logic [DW-1:0] HEIGHT_RST = 7'd3;
  localparam logic [DW-1:0] WIDTH_RST  = 7'd3;

  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = 1 + XW + NBW;
  localparam int EXP_STAGES   = 1 + 3 * NSTEP + 2;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + EXP_STAGES;

  typedef enum logic [1:0] {
    KIND_ONES   = 2'd0,
    KIND_CENTRE = 2'd1,
    KIND_GAUSS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_KIND   = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WIDTH  = 2'd2
  } reg_e;

  typedef struct packed {
    logic [KW-1:0]   kind;
    logic [DW-1:0]   height;
    logic [DW-1:0]   width;
    logic [HWW-1:0]  hw;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } cfg_t;

  typedef struct packed {
    logic          vld;
    logic          pos_ok;
    logic          gauss;
    logic [CW-1:0] coef;
  } meta_t;

  typedef struct packed {
    meta_t          meta;
    logic [NBW-1:0] n;
    logic           big;
    logic [FW-1:0]  f;
  } side_t;

  function automatic logic [HWW-1:0] calc_hw(input logic [DW-1:0] h, input logic [DW-1:0] w);
    return HWW'(14'(h) * 14'(w));
  endfunction

  function automatic logic [NUMW-1:0] calc_num(input logic [DW-1:0] h,
                                                input logic [DW-1:0] w);
    logic [7:0] s;
    logic [6:0] half;
    s    = 8'(h) + 8'(w);
    half = s[7:1];
    return NUMW'({LN2, 1'b0}) + NUMW'(half - 7'd3) * NUMW'(LN3);
  endfunction

  function automatic logic [DENW-1:0] calc_den(input logic [DW-1:0] h,
                                                input logic [DW-1:0] w);
    logic [7:0] s;
    logic [5:0] q;
    s = 8'(h) + 8'(w);
    q = s[7:2];
    return DENW'((12'(q) * 12'(q)) << 1);
  endfunction

endpackage

// ===== rtl/fmcg_cfg.sv =====
// ----------------------------------------------------------------------------
// fmcg_cfg
// APB register file holding mask kind and size, plus derived mask constants
// ----------------------------------------------------------------------------
module fmcg_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [fmcg_pkg::AW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output fmcg_pkg::cfg_t          cfg_o
);
  import fmcg_pkg::*;

  logic [KW-1:0]   kind_q, kind_d;
  logic [DW-1:0]   height_q, height_d;
  logic [DW-1:0]   width_q, width_d;
  logic [HWW-1:0]  hw_q;
  logic [NUMW-1:0] num_q;
  logic [DENW-1:0] den_q;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    kind_d   = kind_q;
    height_d = height_q;
    width_d  = width_q;
    if (wr) begin
      case (paddr[3:2])
        REG_KIND:   kind_d   = pwdata[KW-1:0];
        REG_HEIGHT: height_d = pwdata[DW-1:0];
        REG_WIDTH:  width_d  = pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KIND:   prdata = 32'(kind_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_WIDTH:  prdata = 32'(width_q);
      default:    prdata = 32'd0;
    endcase
  end

  // derived constants follow the registers at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_RST;
      height_q <= HEIGHT_RST;
      width_q  <= WIDTH_RST;
      hw_q     <= calc_hw(HEIGHT_RST, WIDTH_RST);
      num_q    <= calc_num(HEIGHT_RST, WIDTH_RST);
      den_q    <= calc_den(HEIGHT_RST, WIDTH_RST);
    end else begin
      kind_q   <= kind_d;
      height_q <= height_d;
      width_q  <= width_d;
      hw_q     <= calc_hw(height_d, width_d);
      num_q    <= calc_num(height_d, width_d);
      den_q    <= calc_den(height_d, width_d);
    end
  end

  assign cfg_o.kind   = kind_q;
  assign cfg_o.height = height_q;
  assign cfg_o.width  = width_q;
  assign cfg_o.hw     = hw_q;
  assign cfg_o.num    = num_q;
  assign cfg_o.den    = den_q;

endmodule

// ===== rtl/fmcg_front.sv =====
// ----------------------------------------------------------------------------
// fmcg_front
// Position check, fixed coefficients and squared distance times numerator
// ----------------------------------------------------------------------------
module fmcg_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [fmcg_pkg::IW-1:0] row_index_i,
  input  logic [fmcg_pkg::IW-1:0] col_index_i,
  input  fmcg_pkg::cfg_t          cfg_i,
  output logic [fmcg_pkg::NW-1:0] nn_o,
  output fmcg_pkg::meta_t         meta_o
);
  import fmcg_pkg::*;

  logic [IW-1:0]  ch, cw, dr, dc;
  logic [D2W-1:0] d2_d, d2_q;
  logic           cfg_ok, in_mask, pos_ok, centre;
  meta_t          meta1_d, meta1_q, meta2_q;
  logic [NW-1:0]  nn_d, nn_q;

  assign ch = cfg_i.height[DW-1:1];
  assign cw = cfg_i.width[DW-1:1];
  assign dr = (row_index_i >= ch) ? row_index_i - ch : ch - row_index_i;
  assign dc = (col_index_i >= cw) ? col_index_i - cw : cw - col_index_i;
  assign d2_d = D2W'(12'(dr) * 12'(dr)) + D2W'(12'(dc) * 12'(dc));

  assign cfg_ok = (cfg_i.kind == KIND_ONES || cfg_i.kind == KIND_CENTRE ||
                   cfg_i.kind == KIND_GAUSS) &&
                  cfg_i.height >= DW'(3) && cfg_i.width >= DW'(3) &&
                  cfg_i.height <= DW'(MAX_DIM) && cfg_i.width <= DW'(MAX_DIM);
  assign in_mask = (DW'(row_index_i) < cfg_i.height) && (DW'(col_index_i) < cfg_i.width);
  assign pos_ok = cfg_ok & in_mask;
  assign centre = (row_index_i == ch) && (col_index_i == cw);

  always_comb begin
    meta1_d.vld    = take_i;
    meta1_d.pos_ok = pos_ok;
    meta1_d.gauss  = pos_ok && cfg_i.kind == KIND_GAUSS;
    if (!pos_ok) begin
      meta1_d.coef = '0;
    end else if (cfg_i.kind == KIND_CENTRE && centre) begin
      meta1_d.coef = CW'({cfg_i.hw, 12'd0});
    end else begin
      meta1_d.coef = ONE_Q12;
    end
  end

  // rounding offset of half the denominator folded into the dividend
  assign nn_d = NW'(NW'(d2_q) * NW'(cfg_i.num)) + NW'(cfg_i.den[DENW-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
    end else begin
      meta1_q <= meta1_d;
      meta2_q <= meta1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q <= d2_d;
    nn_q <= nn_d;
  end

  assign nn_o   = nn_q;
  assign meta_o = meta2_q;

endmodule

// ===== rtl/fmcg_div.sv =====
// ----------------------------------------------------------------------------
// fmcg_div
// Bit-per-stage division by the mask denominator, then split by ln2
// ----------------------------------------------------------------------------
module fmcg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fmcg_pkg::NW-1:0]   nn_i,
  input  fmcg_pkg::meta_t           meta_i,
  input  logic [fmcg_pkg::DENW-1:0] den_i,
  output fmcg_pkg::side_t           side_o
);
  import fmcg_pkg::*;

  logic [NW-1:0] rem_q [0:XW];
  logic [XW-1:0] quo_q [0:XW];
  logic          ovf_q [0:XW];
  meta_t         meta_q [0:XW];

  logic [XW-1:0]  xr_q   [1:NBW];
  logic [NBW-1:0] nb_q   [1:NBW];
  logic           ovfn_q [1:NBW];
  meta_t          metan_q [1:NBW];

  // quotient above the range is flagged and later forced to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q[0] <= '0;
    end else begin
      meta_q[0] <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= nn_i;
    quo_q[0] <= '0;
    ovf_q[0] <= nn_i >= (NW'(den_i) << XW);
  end

  for (genvar k = 0; k < XW; k++) begin : g_qbit
    localparam int B = XW - 1 - k;
    logic [NW-1:0] dsh;
    logic          ge;
    assign dsh = NW'(den_i) << B;
    assign ge  = rem_q[k] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k+1] <= '0;
      end else begin
        meta_q[k+1] <= meta_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
      quo_q[k+1] <= quo_q[k] | (XW'(ge) << B);
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  for (genvar k = 0; k < NBW; k++) begin : g_nbit
    localparam int B = NBW - 1 - k;
    logic [XW-1:0]  xin, lsh;
    logic [NBW-1:0] nin;
    logic           oin, ge;
    meta_t          min;

    if (k == 0) begin : g_first
      assign xin = quo_q[XW];
      assign nin = '0;
      assign oin = ovf_q[XW];
      assign min = meta_q[XW];
    end else begin : g_next
      assign xin = xr_q[k];
      assign nin = nb_q[k];
      assign oin = ovfn_q[k];
      assign min = metan_q[k];
    end

    assign lsh = XW'(LN2) << B;
    assign ge  = xin >= lsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        metan_q[k+1] <= '0;
      end else begin
        metan_q[k+1] <= min;
      end
    end

    always_ff @(posedge clk_i) begin
      xr_q[k+1]   <= ge ? xin - lsh : xin;
      nb_q[k+1]   <= nin | (NBW'(ge) << B);
      ovfn_q[k+1] <= oin;
    end
  end

  assign side_o.meta = metan_q[NBW];
  assign side_o.n    = nb_q[NBW];
  assign side_o.big  = ovfn_q[NBW] || nb_q[NBW] >= N_ZERO;
  assign side_o.f    = xr_q[NBW][FW-1:0];

endmodule

// ===== rtl/fmcg_exp.sv =====
// ----------------------------------------------------------------------------
// fmcg_exp
// Series for exp(-f), scaling by the mask area and result register
// ----------------------------------------------------------------------------
module fmcg_exp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fmcg_pkg::side_t          side_i,
  input  logic [fmcg_pkg::HWW-1:0] hw_i,
  output logic                     done_o,
  output logic [fmcg_pkg::CW-1:0]  coefficient_o,
  output logic                     position_valid_o
);
  import fmcg_pkg::*;

  logic [FW-1:0] term_q [0:NSTEP];
  logic [EW-1:0] sum_q  [0:NSTEP];
  side_t         side_q [0:NSTEP];

  logic [PW-1:0] prod_q;
  side_t         sidep_q;
  logic [6:0]    sh;
  logic [63:0]   rnd, val;
  logic [CW-1:0] coef_d, coef_q;
  logic          done_q, pos_q;

  // first term needs no multiply: t1 = f
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else begin
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q[0] <= side_i.f;
    sum_q[0]  <= (EW'(1) << 32) - EW'(side_i.f);
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_term
    localparam int J = i + 2;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << QK) / J);
    logic [2*FW-1:0]  pa_q;
    logic [EW-1:0]    suma_q, sumb_q;
    side_t            sidea_q, sideb_q;
    logic [FW-1:0]    y_q, q0, r, q;
    logic [FW+MW-1:0] qm_q;

    assign q0 = FW'(qm_q >> QK);
    assign r  = y_q - FW'(q0 * FW'(J));
    assign q  = (r >= FW'(J)) ? q0 + FW'(1) : q0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sidea_q     <= '0;
        sideb_q     <= '0;
        side_q[i+1] <= '0;
      end else begin
        sidea_q     <= side_q[i];
        sideb_q     <= sidea_q;
        side_q[i+1] <= sideb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      pa_q   <= (2*FW)'(term_q[i]) * (2*FW)'(side_q[i].f);
      suma_q <= sum_q[i];
      y_q    <= pa_q[2*FW-1:FW];
      qm_q   <= (FW+MW)'(pa_q[2*FW-1:FW]) * (FW+MW)'(RECIP);
      sumb_q <= suma_q;
      term_q[i+1] <= q;
      if (J % 2 == 1) begin
        sum_q[i+1] <= sumb_q - EW'(q);
      end else begin
        sum_q[i+1] <= sumb_q + EW'(q);
      end
    end
  end

  assign sh  = SHIFT_BASE + 7'(sidep_q.n);
  assign rnd = 64'(prod_q) + (64'd1 << (sh - 7'd1));
  assign val = rnd >> sh;

  always_comb begin
    if (!sidep_q.meta.gauss) begin
      coef_d = sidep_q.meta.coef;
    end else if (sidep_q.big) begin
      coef_d = '0;
    end else if (val > 64'(COEF_MAX)) begin
      coef_d = COEF_MAX;
    end else begin
      coef_d = val[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidep_q <= '0;
      done_q  <= 1'b0;
      pos_q   <= 1'b0;
    end else begin
      sidep_q <= side_q[NSTEP];
      done_q  <= sidep_q.meta.vld;
      pos_q   <= sidep_q.meta.vld & sidep_q.meta.pos_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(hw_i) * PW'(sum_q[NSTEP]);
    coef_q <= coef_d;
  end

  assign done_o           = done_q;
  assign coefficient_o    = coef_q;
  assign position_valid_o = pos_q;

endmodule

// ===== rtl/filter_mask_coefficient_generator_unit.sv =====
// ----------------------------------------------------------------------------
// filter_mask_coefficient_generator_unit
// Returns one coefficient of a constant, centre-weighted or gaussian mask
// ----------------------------------------------------------------------------
//  port group   direction  transfer
//  command      in         row_index_i, col_index_i taken when start & !busy
//  result       out        coefficient_o, position_valid_o while done_o (1 cycle)
//  apb config   in/out     register write when psel & penable & pwrite
//
//  a request is taken in every cycle that start is high; busy stays low
//  each result leaves in request order
//  the pipeline holds the 37-stage divider, the 6-stage ln2 split and the
//  three stages per series term (multiply, reciprocal multiply, correction)
//  reset clears the valid chain and loads kind 0, height 3, width 3
//  the result side has no back-pressure, so the pipeline never stalls
// ----------------------------------------------------------------------------
module filter_mask_coefficient_generator_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [fmcg_pkg::IW-1:0] row_index_i,
  input  logic [fmcg_pkg::IW-1:0] col_index_i,
  output logic                    done_o,
  output logic [fmcg_pkg::CW-1:0] coefficient_o,
  output logic                    position_valid_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [fmcg_pkg::AW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import fmcg_pkg::*;

  cfg_t          cfg;
  meta_t         meta_f;
  logic [NW-1:0] nn_f;
  side_t         side_d;
  logic          take;

  assign busy = 1'b0;
  assign take = start & ~busy;

  fmcg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fmcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .cfg_i       (cfg),
    .nn_o        (nn_f),
    .meta_o      (meta_f)
  );

  fmcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .nn_i   (nn_f),
    .meta_i (meta_f),
    .den_i  (cfg.den),
    .side_o (side_d)
  );

  fmcg_exp u_exp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .side_i           (side_d),
    .hw_i             (cfg.hw),
    .done_o           (done_o),
    .coefficient_o    (coefficient_o),
    .position_valid_o (position_valid_o)
  );

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("result strobe missing after a request");

  a_zero_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !position_valid_o |-> coefficient_o == '0)
    else $error("nonzero coefficient for a position outside the mask");

  a_valid_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    position_valid_o |-> done_o)
    else $error("position valid raised without a result strobe");

endmodule

// ===== tb/sv/filter_mask_coefficient_generator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filter_mask_coefficient_generator_unit_tb
// Drives row/column requests under several mask settings, takes or predicts
// each coefficient in fixed point and checks every result in request order
// ----------------------------------------------------------------------------
module filter_mask_coefficient_generator_unit_tb;
  import fmcg_pkg::*;

  typedef struct {
    logic [CW-1:0] coef;
    logic          valid;
  } coef_t;

  typedef struct {
    logic [1:0]    kind;
    logic [6:0]    h;
    logic [6:0]    w;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    bit            known;
    logic [CW-1:0] coef;
    logic          valid;
  } dir_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [IW-1:0] row_index_i = '0;
  logic [IW-1:0] col_index_i = '0;
  logic          done_o;
  logic [CW-1:0] coefficient_o;
  logic          position_valid_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // mirror of the mask registers
  logic [1:0] cur_kind = KIND_RST;
  logic [6:0] cur_h = HEIGHT_RST;
  logic [6:0] cur_w = WIDTH_RST;

  bit            req_known = 0;
  logic [CW-1:0] req_coef = '0;
  logic          req_valid = 1'b0;
  coef_t         pending_coefs[$];
  int            err_count = 0;
  int            idle_pct = 0;

  filter_mask_coefficient_generator_unit uut (
    .clk_i, .rst_ni, .start, .busy, .row_index_i, .col_index_i, .done_o,
    .coefficient_o, .position_valid_o, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [CW-1:0] gauss_coef(logic [6:0] row, logic [6:0] col,
                                               logic [6:0] h, logic [6:0] w);
    bit [63:0] s, q, half, num, den, dr, dc, d2, x, n, f, e, term, hw, sh, res;
    bit [63:0] hc, wc, rr, cc;
    s    = 64'(h) + 64'(w);
    q    = s / 4;
    half = s / 2;
    num  = 2 * 64'(LN2) + (half - 3) * 64'(LN3);
    den  = 2 * q * q;
    hc   = 64'(h) / 2;
    wc   = 64'(w) / 2;
    rr   = 64'(row);
    cc   = 64'(col);
    dr   = (rr >= hc) ? rr - hc : hc - rr;
    dc   = (cc >= wc) ? cc - wc : wc - cc;
    d2   = dr * dr + dc * dc;
    x    = (d2 * num + den / 2) / den;
    n    = x / 64'(LN2);
    f    = x - n * 64'(LN2);
    if (n >= 40) return '0;
    e    = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int j = 1; j < TERMS; j++) begin
      term = ((term * f) >> 32) / 64'(j);
      if (j % 2) e = e - term;
      else e = e + term;
    end
    hw  = 64'(h) * 64'(w);
    sh  = 20 + n;
    res = (hw * e + (64'd1 << (sh - 1))) >> sh;
    return (res > 64'(COEF_MAX)) ? COEF_MAX : res[CW-1:0];
  endfunction

  function automatic coef_t predict_coef(logic [IW-1:0] row, logic [IW-1:0] col);
    coef_t r;
    bit [31:0] hw;
    r.coef  = '0;
    r.valid = 1'b0;
    if (cur_kind > KIND_GAUSS || cur_h < 7'd3 || cur_w < 7'd3 ||
        cur_h > 7'(MAX_DIM) || cur_w > 7'(MAX_DIM) ||
        7'(row) >= cur_h || 7'(col) >= cur_w)
      return r;
    r.valid = 1'b1;
    hw = 32'(cur_h) * 32'(cur_w);
    case (cur_kind)
      KIND_ONES: r.coef = ONE_Q12;
      KIND_CENTRE: begin
        if (7'(row) == cur_h / 7'd2 && 7'(col) == cur_w / 7'd2) r.coef = CW'(hw * 4096);
        else r.coef = ONE_Q12;
      end
      default: r.coef = gauss_coef(7'(row), 7'(col), cur_h, cur_w);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // transfers in and out are both taken at the rising edge
  always @(posedge clk_i) begin
    coef_t want;
    if (rst_ni && done_o) begin
      if (pending_coefs.size() == 0) begin
        report_mismatch("unexpected result", longint'(coefficient_o), 0);
      end else begin
        want = pending_coefs.pop_front();
        if (coefficient_o !== want.coef)
          report_mismatch("coefficient", coefficient_o, want.coef);
        if (position_valid_o !== want.valid)
          report_mismatch("position_valid", position_valid_o, want.valid);
      end
    end
    if (rst_ni && start && !busy) begin
      if (req_known) begin
        want.coef  = req_coef;
        want.valid = req_valid;
      end else begin
        want = predict_coef(row_index_i, col_index_i);
      end
      pending_coefs.push_back(want);
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [31:0] data, bit beyond = 0);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= beyond ? AW'(12) : AW'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!beyond) begin
      case (idx)
        REG_KIND:   cur_kind = data[1:0];
        REG_HEIGHT: cur_h = data[6:0];
        default:    cur_w = data[6:0];
      endcase
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mask(logic [1:0] kind, logic [6:0] h, logic [6:0] w);
    wait_drained();
    apb_write(REG_KIND, 32'(kind));
    apb_write(REG_HEIGHT, 32'(h));
    apb_write(REG_WIDTH, 32'(w));
  endtask

  task automatic send_request(logic [IW-1:0] row, logic [IW-1:0] col);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start       <= 1'b1;
    row_index_i <= row;
    col_index_i <= col;
    do @(posedge clk_i); while (busy);
  endtask

  dir_row_t dir_rows[20] = '{
    '{KIND_ONES,   3,   3,  0,  0, 1, 4096,     1},
    '{KIND_ONES,   3,   3,  2,  2, 1, 4096,     1},
    '{KIND_ONES,   3,   3,  3,  0, 1, 0,        0},
    '{KIND_ONES,   3,   3,  0, 63, 1, 0,        0},
    '{KIND_CENTRE, 3,   3,  1,  1, 1, 36864,    1},
    '{KIND_CENTRE, 3,   3,  0,  1, 1, 4096,     1},
    '{KIND_CENTRE, 64, 64, 32, 32, 1, 16777216, 1},
    '{KIND_CENTRE, 64, 64, 63, 63, 1, 4096,     1},
    '{KIND_GAUSS,  64, 64, 32, 32, 1, 16777216, 1},
    '{KIND_GAUSS,  64, 64,  0,  0, 0, 0,        0},
    '{KIND_GAUSS,  64, 64, 63,  0, 0, 0,        0},
    '{KIND_GAUSS,  3,   3,  0,  0, 0, 0,        0},
    '{KIND_GAUSS,  3,   3,  1,  1, 1, 36864,    1},
    '{KIND_GAUSS,  64,  3, 63,  2, 0, 0,        0},
    '{KIND_GAUSS,  3,  64,  0, 63, 0, 0,        0},
    '{2'd3,        10, 10,  1,  1, 1, 0,        0},
    '{KIND_GAUSS,  2,  64,  0,  0, 1, 0,        0},
    '{KIND_GAUSS,  65,  5,  0,  0, 1, 0,        0},
    '{KIND_ONES,   127, 127, 63, 63, 1, 0,      0},
    '{KIND_ONES,   0,   0,  0,  0, 1, 0,        0}
  };

  initial begin
    logic [1:0] kind;
    logic [6:0] h, w;
    logic [IW-1:0] row, col;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // an address past the register list must leave the mask alone
    apb_write(REG_KIND, 32'hFFFF_FFFF, 1);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind != cur_kind || dir_rows[i].h != cur_h ||
          dir_rows[i].w != cur_w)
        set_mask(dir_rows[i].kind, dir_rows[i].h, dir_rows[i].w);
      req_known <= dir_rows[i].known;
      req_coef  <= dir_rows[i].coef;
      req_valid <= dir_rows[i].valid;
      send_request(dir_rows[i].row, dir_rows[i].col);
    end
    req_known <= 1'b0;

    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: begin kind = KIND_GAUSS; h = 7'd64; w = 7'd64; end
        1: begin kind = KIND_GAUSS; h = 7'd3; w = 7'd3; end
        2: begin kind = KIND_GAUSS; h = 7'd64; w = 7'd3; end
        3: begin kind = KIND_GAUSS; h = 7'd3; w = 7'd64; end
        4: begin
          kind = KIND_CENTRE;
          h = 7'($urandom_range(3, 64));
          w = 7'($urandom_range(3, 64));
        end
        5: begin kind = 2'd3; h = 7'd20; w = 7'd20; end
        6: begin
          kind = KIND_GAUSS;
          h = 7'($urandom_range(0, 127));
          w = 7'($urandom_range(0, 127));
        end
        7: begin
          kind = KIND_ONES;
          h = 7'($urandom_range(3, 64));
          w = 7'($urandom_range(3, 64));
        end
        default: begin
          kind = KIND_GAUSS;
          h = 7'($urandom_range(3, 64));
          w = 7'($urandom_range(3, 64));
        end
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 75;
        default: idle_pct = 19;
      endcase
      set_mask(kind, h, w);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(99) < 80 && cur_h >= 7'd3 && cur_w >= 7'd3) begin
          row = IW'($urandom_range(0, (cur_h > 7'd64 ? 64 : int'(cur_h)) - 1));
          col = IW'($urandom_range(0, (cur_w > 7'd64 ? 64 : int'(cur_w)) - 1));
        end else begin
          row = IW'($urandom_range(0, 63));
          col = IW'($urandom_range(0, 63));
        end
        send_request(row, col);
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fmcg_pkg.sv
rtl/fmcg_cfg.sv
rtl/fmcg_front.sv
rtl/fmcg_div.sv
rtl/fmcg_exp.sv
rtl/filter_mask_coefficient_generator_unit.sv
tb/sv/filter_mask_coefficient_generator_unit_tb.sv
